/* sv/pgd_pkg.sv */
package pgd_pkg;

	localparam int IN_WIDTH_DEF      = 24;
	localparam int OUT_FRAC_BITS_DEF = 15;
	localparam int UNIT_FRAC         = 30;
	// A normalized magnitude lies below 2^31.
	localparam int NORM_W            = 31;
	// Weighted sum: energy (up to 32 bits) times a unit component (31 bits), plus one carry.
	localparam int SUM_W             = 64;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ENERGY   = 2'd1,
		ST_DEGEN    = 2'd2,
		ST_RESERVED = 2'd3
	} status_t;

endpackage

/* sv/pgd_if.sv */
interface pgd_in_if
	import pgd_pkg::*;
#(
	parameter int IN_WIDTH = IN_WIDTH_DEF
);
	logic                       valid;
	logic                       ready;
	logic signed [IN_WIDTH-1:0] electron_dir_x;
	logic signed [IN_WIDTH-1:0] electron_dir_y;
	logic signed [IN_WIDTH-1:0] electron_dir_z;
	logic signed [IN_WIDTH-1:0] positron_dir_x;
	logic signed [IN_WIDTH-1:0] positron_dir_y;
	logic signed [IN_WIDTH-1:0] positron_dir_z;
	logic        [IN_WIDTH-1:0] electron_energy;
	logic        [IN_WIDTH-1:0] positron_energy;

	modport source (output valid, electron_dir_x, electron_dir_y, electron_dir_z,
		positron_dir_x, positron_dir_y, positron_dir_z, electron_energy,
		positron_energy, input ready);
	modport sink (input valid, electron_dir_x, electron_dir_y, electron_dir_z,
		positron_dir_x, positron_dir_y, positron_dir_z, electron_energy,
		positron_energy, output ready);
endinterface

interface pgd_out_if
	import pgd_pkg::*;
#(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [OUT_FRAC_BITS:0] gamma_dir_x;
	logic signed [OUT_FRAC_BITS:0] gamma_dir_y;
	logic signed [OUT_FRAC_BITS:0] gamma_dir_z;
	logic        [1:0]             status;

	modport source (output valid, gamma_dir_x, gamma_dir_y, gamma_dir_z, status,
		input ready);
	modport sink (input valid, gamma_dir_x, gamma_dir_y, gamma_dir_z, status,
		output ready);
endinterface

/* sv/pgd_norm.sv */
// Pipelined 3-vector normalizer. A new vector may enter every cycle when en is high.
// Stages: magnitudes, alignment shift, squares, sum, 16 restoring square-root
// stages (two result bits each), three dividers by r (one quotient bit per stage).
module pgd_norm
	import pgd_pkg::*;
#(
	parameter int VW = 64,
	parameter int F  = 30,
	parameter int SW = 8
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [VW-1:0] vx,
	input  logic signed [VW-1:0] vy,
	input  logic signed [VW-1:0] vz,
	input  logic [SW-1:0]        side_in,
	output logic signed [F+1:0]  ux,
	output logic signed [F+1:0]  uy,
	output logic signed [F+1:0]  uz,
	output logic                 zero,
	output logic [SW-1:0]        side_out
);
	localparam int MW  = VW;
	localparam int LW  = $clog2(MW + 1);
	localparam int SQW = 2 * NORM_W + 2;
	localparam int RW  = NORM_W + 2;
	localparam int NW  = NORM_W + F;
	localparam int QW  = F + 2;

	// Stage 1: magnitudes and signs.
	logic [MW-1:0] m_s1 [3];
	logic [2:0]    neg_s1;
	logic [SW-1:0] side_s1;
	logic signed [VW-1:0] vin [3];
	assign vin[0] = vx;
	assign vin[1] = vy;
	assign vin[2] = vz;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vin[i][VW-1];
				m_s1[i]   <= vin[i][VW-1] ? MW'(-vin[i]) : MW'(vin[i]);
			end
			side_s1 <= side_in;
		end
	end

	// Stage 2: leading-one position of the OR of the magnitudes gives the shift.
	logic [MW-1:0] orv;
	logic [LW-1:0] lead;
	always_comb begin
		orv  = m_s1[0] | m_s1[1] | m_s1[2];
		lead = '0;
		for (int b = 0; b < MW; b++) begin
			if (orv[b]) lead = LW'(b);
		end
	end

	logic [MW-1:0] lead_s2_m [3];
	logic [LW-1:0] lead_s2;
	logic          zero_s2;
	logic [2:0]    neg_s2;
	logic [SW-1:0] side_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			lead_s2_m <= m_s1;
			lead_s2   <= lead;
			zero_s2   <= (orv == '0);
			neg_s2    <= neg_s1;
			side_s2   <= side_s1;
		end
	end

	// Stage 3: align so the largest lies in [2^30, 2^31).
	// A left shift only happens when every magnitude is below 2^30, so the
	// magnitudes are first brought to the aligned width and then shifted.
	logic [NORM_W-1:0] a_s3 [3];
	logic              zero_s3;
	logic [2:0]        neg_s3;
	logic [SW-1:0]     side_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (lead_s2 >= LW'(NORM_W - 1))
					a_s3[i] <= NORM_W'(lead_s2_m[i] >> (lead_s2 - LW'(NORM_W - 1)));
				else
					a_s3[i] <= NORM_W'(lead_s2_m[i]) << (LW'(NORM_W - 1) - lead_s2);
			end
			zero_s3 <= zero_s2;
			neg_s3  <= neg_s2;
			side_s3 <= side_s2;
		end
	end

	// Stage 4: squares, one multiplier per component.
	logic [SQW-1:0]    sq_s4 [3];
	logic [NORM_W-1:0] a_s4 [3];
	logic              zero_s4;
	logic [2:0]        neg_s4;
	logic [SW-1:0]     side_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sq_s4[i] <= SQW'(a_s3[i]) * SQW'(a_s3[i]);
			a_s4    <= a_s3;
			zero_s4 <= zero_s3;
			neg_s4  <= neg_s3;
			side_s4 <= side_s3;
		end
	end

	// Square-root pipeline: each stage resolves two result bits.
	localparam int NST = SQW / 4;
	logic [SQW-1:0]    rx  [NST+1];
	logic [RW-1:0]     rr  [NST+1];
	logic [NORM_W-1:0] ra  [NST+1][3];
	logic              rz  [NST+1];
	logic [2:0]        rn  [NST+1];
	logic [SW-1:0]     rs  [NST+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rx[0] <= sq_s4[0] + sq_s4[1] + sq_s4[2];
			rr[0] <= '0;
			ra[0] <= a_s4;
			rz[0] <= zero_s4;
			rn[0] <= neg_s4;
			rs[0] <= side_s4;
		end
	end

	for (genvar k = 0; k < NST; k++) begin : g_sqrt
		logic [SQW-1:0] x1, x2;
		logic [RW-1:0]  r1, r2;
		logic [SQW+1:0] t1, t2;
		always_comb begin
			t1 = (SQW+2)'({2'b0, rx[k]} -
				(({(SQW+2)'(rr[k]), 2'b01}) << (SQW - 4 * k - 2)));
			if (!t1[SQW+1]) begin
				x1 = t1[SQW-1:0];
				r1 = {rr[k][RW-2:0], 1'b1};
			end else begin
				x1 = rx[k];
				r1 = {rr[k][RW-2:0], 1'b0};
			end
			t2 = (SQW+2)'({2'b0, x1} -
				(({(SQW+2)'(r1), 2'b01}) << (SQW - 4 * k - 4)));
			if (!t2[SQW+1]) begin
				x2 = t2[SQW-1:0];
				r2 = {r1[RW-2:0], 1'b1};
			end else begin
				x2 = x1;
				r2 = {r1[RW-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rx[k+1] <= x2;
				rr[k+1] <= r2;
				ra[k+1] <= ra[k];
				rz[k+1] <= rz[k];
				rn[k+1] <= rn[k];
				rs[k+1] <= rs[k];
			end
		end
	end

	// Division stages: numerator a*2^F + r/2, restoring, one quotient bit per stage.
	logic [NW:0]   dn [QW+1][3];
	logic [QW-1:0] dq [QW+1][3];
	logic [RW-1:0] dr [QW+1];
	logic          dz [QW+1];
	logic [2:0]    dg [QW+1];
	logic [SW-1:0] ds [QW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dn[0][i] <= ((NW+1)'(ra[NST][i]) << F) + (NW+1)'(rr[NST] >> 1);
				dq[0][i] <= '0;
			end
			dr[0] <= rr[NST];
			dz[0] <= rz[NST];
			dg[0] <= rn[NST];
			ds[0] <= rs[NST];
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int SH = QW - 1 - k;
		logic [NW:0]   nn [3];
		logic [QW-1:0] qq [3];
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				if ((dn[k][i] >> SH) >= (NW+1)'(dr[k])) begin
					nn[i] = dn[k][i] - ((NW+1)'(dr[k]) << SH);
					qq[i] = dq[k][i] | (QW'(1) << SH);
				end else begin
					nn[i] = dn[k][i];
					qq[i] = dq[k][i];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dn[k+1] <= nn;
				dq[k+1] <= qq;
				dr[k+1] <= dr[k];
				dz[k+1] <= dz[k];
				dg[k+1] <= dg[k];
				ds[k+1] <= ds[k];
			end
		end
	end

	always_comb begin
		ux = dg[QW][0] ? -$signed(dq[QW][0]) : $signed(dq[QW][0]);
		uy = dg[QW][1] ? -$signed(dq[QW][1]) : $signed(dq[QW][1]);
		uz = dg[QW][2] ? -$signed(dq[QW][2]) : $signed(dq[QW][2]);
	end
	assign zero     = dz[QW];
	assign side_out = ds[QW];

endmodule

/* sv/pgd_merge.sv */
// Merges the two track lanes: energy-weighted, negated sum.
module pgd_merge
	import pgd_pkg::*;
#(
	parameter int IN_WIDTH = IN_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [IN_WIDTH-1:0]        ee,
	input  logic [IN_WIDTH-1:0]        ep,
	input  logic signed [UNIT_FRAC+1:0] ue [3],
	input  logic signed [UNIT_FRAC+1:0] up [3],
	output logic signed [SUM_W-1:0]    w [3]
);
	logic signed [SUM_W-1:0] pe_s1 [3];
	logic signed [SUM_W-1:0] pp_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pe_s1[i] <= SUM_W'($signed({1'b0, ee})) * SUM_W'(ue[i]);
				pp_s1[i] <= SUM_W'($signed({1'b0, ep})) * SUM_W'(up[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				w[i] <= -(pe_s1[i] + pp_s1[i]);
		end
	end
endmodule

/* sv/pair_gamma_direction_top.sv */
// Channel   Dir  Payload
// in_ch     in   electron/positron directions (IN_WIDTH signed) and energies
// out_ch    out  gamma_dir_x/y/z (Q1.OUT_FRAC_BITS) and 2-bit status
//
// One word is accepted per cycle while the output is not stalled. The pipeline is the
// two normalizer pipelines in series (square root plus dividers) and the merge.
// Reset clears the valid bits of the pipeline; payload is not reset.
// The whole pipeline advances when the output register is empty or taken,
// so a stall at the output holds every stage.
module pair_gamma_direction_top
	import pgd_pkg::*;
#(
	parameter int IN_WIDTH      = IN_WIDTH_DEF,
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	pgd_in_if.sink    in_ch,
	pgd_out_if.source out_ch
);
	localparam int VW1 = IN_WIDTH;
	localparam int LAT1 = 4 + (2 * NORM_W + 2) / 4 + 1 + UNIT_FRAC + 2 + 1;
	localparam int LAT2 = 4 + (2 * NORM_W + 2) / 4 + 1 + OUT_FRAC_BITS + 2 + 1;
	localparam int LATM = 2;
	localparam int LAT  = LAT1 + LATM + LAT2;

	logic en;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	// Valid shift line across the whole pipeline.
	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_ch.valid};
		end
	end

	// Electron and positron lanes; the electron lane's side band carries energies and the energy error.
	localparam int SW1 = 2 * IN_WIDTH + 1;
	logic signed [UNIT_FRAC+1:0] ue [3];
	logic signed [UNIT_FRAC+1:0] up [3];
	logic ze, zp;
	logic [SW1-1:0] side_e;
	logic [SW1-1:0] side_in;
	assign side_in = {(in_ch.electron_energy == '0) || (in_ch.positron_energy == '0),
		in_ch.electron_energy, in_ch.positron_energy};

	pgd_norm #(.VW(VW1), .F(UNIT_FRAC), .SW(SW1)) u_lane_e (
		.clk(clk), .en(en),
		.vx(in_ch.electron_dir_x), .vy(in_ch.electron_dir_y), .vz(in_ch.electron_dir_z),
		.side_in(side_in), .ux(ue[0]), .uy(ue[1]), .uz(ue[2]),
		.zero(ze), .side_out(side_e)
	);
	pgd_norm #(.VW(VW1), .F(UNIT_FRAC), .SW(1)) u_lane_p (
		.clk(clk), .en(en),
		.vx(in_ch.positron_dir_x), .vy(in_ch.positron_dir_y), .vz(in_ch.positron_dir_z),
		.side_in(1'b0), .ux(up[0]), .uy(up[1]), .uz(up[2]),
		.zero(zp), .side_out()
	);

	logic signed [SUM_W-1:0] w [3];
	pgd_merge #(.IN_WIDTH(IN_WIDTH)) u_merge (
		.clk(clk), .en(en),
		.ee(side_e[2*IN_WIDTH-1:IN_WIDTH]), .ep(side_e[IN_WIDTH-1:0]),
		.ue(ue), .up(up), .w(w)
	);

	// Status code delayed alongside the merge.
	logic [1:0] st_s1, st_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= side_e[SW1-1] ? ST_ENERGY : ((ze || zp) ? ST_DEGEN : ST_OK);
			st_s2 <= st_s1;
		end
	end

	logic signed [OUT_FRAC_BITS+1:0] g [3];
	logic gz;
	logic [1:0] st_out;
	pgd_norm #(.VW(SUM_W), .F(OUT_FRAC_BITS), .SW(2)) u_final (
		.clk(clk), .en(en),
		.vx(w[0]), .vy(w[1]), .vz(w[2]),
		.side_in(st_s2), .ux(g[0]), .uy(g[1]), .uz(g[2]),
		.zero(gz), .side_out(st_out)
	);

	// Output register: saturate and apply status.
	localparam logic signed [OUT_FRAC_BITS+1:0] TOP = (OUT_FRAC_BITS+2)'(1) <<< OUT_FRAC_BITS;
	logic [1:0] fst;
	logic signed [OUT_FRAC_BITS:0] c [3];
	always_comb begin
		fst = (st_out != ST_OK) ? st_out : (gz ? ST_DEGEN : ST_OK);
		for (int i = 0; i < 3; i++) begin
			if (fst != ST_OK) c[i] = '0;
			else if (g[i] > TOP - 1) c[i] = (OUT_FRAC_BITS+1)'(TOP - 1);
			else c[i] = g[i][OUT_FRAC_BITS:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (en) begin
			out_ch.valid <= vld_q[LAT-1];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.gamma_dir_x <= c[0];
			out_ch.gamma_dir_y <= c[1];
			out_ch.gamma_dir_z <= c[2];
			out_ch.status      <= fst;
		end
	end
endmodule
